// ----- hdl/stereo_downmix_linear_resampler_assert.svh -----
// Assertion macros shared by the resampler RTL.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef STEREO_DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define SDLR_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SDLR_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sdlr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdlr_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int RATE_W           = 16;
   localparam int CHAN_W           = 2;
   localparam int CSR_ADDR_W       = 2;
   localparam int MAX_BLOCK_FRAMES = 4096;
   localparam int FRAMES_W         = 13;
   localparam int COUNT_W          = 14;
   localparam int PROD_W           = 32;
   localparam int FRAC_BITS        = 16;
   localparam int STEP_W           = 4;
   localparam int HOLD_SLOTS       = 8;
   localparam int HOLD_AW          = 3;
   localparam int MAX_OUT          = 6;
   localparam int NRES_W           = 3;

   localparam logic [RATE_W-1:0] IN_RATE_LO  = 16'd16000;
   localparam logic [RATE_W-1:0] IN_RATE_HI  = 16'd48000;
   localparam logic [RATE_W-1:0] OUT_RATE_LO = 16'd8000;
   localparam logic [RATE_W-1:0] OUT_RATE_HI = 16'd48000;
   localparam logic [RATE_W-1:0] RATE_RESET  = 16'd48000;
   localparam logic [CHAN_W-1:0] CHAN_RESET  = 2'd2;
   localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;

   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_RATE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_RATE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_DIV   = 6'b000100,
      S_PUSH  = 6'b001000,
      S_FILL  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v,
                                                    input logic [RATE_W-1:0] lo,
                                                    input logic [RATE_W-1:0] hi);
      logic [RATE_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/stereo_downmix_linear_resampler.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_downmix_linear_resampler_assert.svh"

// Downmixes each stereo frame to (L+R)/2 (left only in mono mode) and resamples
// each block, closed by tlast or at 4096 frames, from input_rate to
// output_rate by linear interpolation; the block yields max(1, n*out/in) items
// and the last carries tlast. Rates are clamped and latched on a block's first
// frame, so write the registers between blocks. One frame at a time is worked:
// it passes through the check and emit states, plus a bit-serial division for each
// interpolated result it completes (0 to 3, about output_rate/input_rate per
// frame), plus end-of-block fills and results handed to the output register.
// The bit-serial loop forms one fraction bit by restoring division and folds
// it into the interpolation product in the same cycle.
module stereo_downmix_linear_resampler
   import sdlr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,  // left_sample, right_sample
   input  wire logic                  req_tlast,  // block_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,  // out_sample
   output logic                       rsp_tlast,  // run_end
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [RATE_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic [RATE_W-1:0]          in_rate_ff, in_rate_in;
   logic [RATE_W-1:0]          out_rate_ff, out_rate_in;
   logic [CHAN_W-1:0]          chan_ff, chan_in;
   logic [RATE_W-1:0]          rin_ff, rin_in;
   logic [RATE_W-1:0]          rout_ff, rout_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] mono_ff, mono_in;
   logic signed [SAMPLE_W:0]   diff_ff, diff_in;
   logic                       end_ff, end_in;
   logic [FRAMES_W-1:0]        k_ff, k_in;
   logic [COUNT_W-1:0]         c_ff, c_in;
   logic [COUNT_W-1:0]         e_ff, e_in;
   logic [PROD_W-1:0]          crin_ff, crin_in;
   logic [PROD_W-1:0]          erin_ff, erin_in;
   logic [PROD_W-1:0]          krout_ff, krout_in;
   logic [FRAC_BITS-1:0]       rem_ff, rem_in;
   logic signed [2*SAMPLE_W:0] acc_ff, acc_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [NRES_W-1:0]          nres_ff, nres_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_last_ff, rsp_last_in;
   logic [SAMPLE_W-1:0]        hold_ff [HOLD_SLOTS];

   logic                       req_fire;
   logic signed [SAMPLE_W-1:0] left_s, right_s, mono_new;
   logic signed [SAMPLE_W:0]   pair_sum, pair_rnd;
   logic [PROD_W-1:0]          rin_w, rout_w, rin2_w, rout2_w, krout_n, krout_2;
   logic [PROD_W-1:0]          rem_wide;
   logic                       interp_go, fill_go, lt_e, last_e, rel_ok, emit_ok;
   logic                       slot_free, hold_room, hold_we, rsp_load;
   logic [SAMPLE_W-1:0]        hold_wdata;
   logic [FRAC_BITS:0]         div_t;
   logic                       div_bit;
   logic [FRAC_BITS-1:0]       rem_step;
   logic signed [2*SAMPLE_W:0] acc_step;
   logic signed [SAMPLE_W:0]   interp_sum;

   assign req_fire = req_tvalid && (state_ff == S_IDLE);
   assign left_s   = req_tdata[15:0];
   assign right_s  = req_tdata[31:16];
   assign pair_sum = {left_s[SAMPLE_W-1], left_s} + {right_s[SAMPLE_W-1], right_s};
   // truncate toward zero: bias negative sums by one before the halving shift
   assign pair_rnd = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
   assign mono_new = (chan_ff == CHAN_MONO) ? left_s : pair_rnd[SAMPLE_W:1];

   assign rin_w   = {{(PROD_W-RATE_W){1'b0}}, rin_ff};
   assign rout_w  = {{(PROD_W-RATE_W){1'b0}}, rout_ff};
   assign rin2_w  = {{(PROD_W-RATE_W-1){1'b0}}, rin_ff, 1'b0};
   assign rout2_w = {{(PROD_W-RATE_W-1){1'b0}}, rout_ff, 1'b0};
   assign krout_n = krout_ff + rout_w;   // (k+1)*rout
   assign krout_2 = krout_ff + rout2_w;  // (k+2)*rout

   // result c falls between the previous frame and this one
   assign interp_go = (k_ff != '0) && (crin_ff < krout_ff);
   assign rem_wide  = crin_ff + rout_w - krout_ff;
   // c < count, count = max(1, (k+1)*rout/rin)
   assign fill_go   = (c_ff == '0) || ((crin_ff + rin_w) <= krout_n);
   assign lt_e      = (e_ff == '0) || ((erin_ff + rin_w) <= krout_n);
   assign last_e    = (erin_ff + rin2_w) > krout_n;
   // a later result of the block is certain
   assign rel_ok    = (erin_ff + rin2_w) <= krout_2;
   assign emit_ok   = (e_ff != c_ff) && (nres_ff < NRES_W'(MAX_OUT)) &&
                      (end_ff ? lt_e : rel_ok);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign hold_room = COUNT_W'(c_ff - e_ff) < COUNT_W'(HOLD_SLOTS);

   // one restoring-division bit per cycle, MSB first, fed straight into the product
   assign div_t    = {rem_ff, 1'b0};
   assign div_bit  = div_t >= {1'b0, rout_ff};
   assign rem_step = div_bit ? FRAC_BITS'(div_t - {1'b0, rout_ff}) : div_t[FRAC_BITS-1:0];
   assign acc_step = (acc_ff <<< 1) +
                     (div_bit ? {{SAMPLE_W{diff_ff[SAMPLE_W]}}, diff_ff}
                              : {(2*SAMPLE_W+1){1'b0}});
   assign interp_sum = {prev_ff[SAMPLE_W-1], prev_ff} + acc_ff[2*SAMPLE_W:FRAC_BITS];

   assign rsp_load = (state_ff == S_EMIT) && emit_ok && slot_free;

   always_comb begin
      state_in    = state_ff;
      in_rate_in  = in_rate_ff;
      out_rate_in = out_rate_ff;
      chan_in     = chan_ff;
      rin_in      = rin_ff;
      rout_in     = rout_ff;
      prev_in     = prev_ff;
      mono_in     = mono_ff;
      diff_in     = diff_ff;
      end_in      = end_ff;
      k_in        = k_ff;
      c_in        = c_ff;
      e_in        = e_ff;
      crin_in     = crin_ff;
      erin_in     = erin_ff;
      krout_in    = krout_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      nres_in     = nres_ff;
      rsp_last_in = rsp_last_ff;
      hold_we     = 1'b0;
      hold_wdata  = mono_ff;

      if (csr_wen) begin
         unique case (csr_addr)
            CSR_INPUT_RATE:    in_rate_in  = csr_wdata;
            CSR_OUTPUT_RATE:   out_rate_in = csr_wdata;
            CSR_CHANNEL_COUNT: chan_in     = csr_wdata[CHAN_W-1:0];
            default:           ;
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = end_ff && last_e;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mono_in = mono_new;
               end_in  = req_tlast || (k_ff == FRAMES_W'(MAX_BLOCK_FRAMES - 1));
               nres_in = '0;
               if (k_ff == '0) begin
                  rin_in  = clamp_rate(in_rate_ff, IN_RATE_LO, IN_RATE_HI);
                  rout_in = clamp_rate(out_rate_ff, OUT_RATE_LO, OUT_RATE_HI);
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (interp_go) begin
               rem_in   = rem_wide[FRAC_BITS-1:0];
               acc_in   = '0;
               diff_in  = {mono_ff[SAMPLE_W-1], mono_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
               step_in  = '1;
               state_in = S_DIV;
            end else if (end_ff) begin
               state_in = S_FILL;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            rem_in  = rem_step;
            acc_in  = acc_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            hold_we    = hold_room;
            hold_wdata = interp_sum[SAMPLE_W-1:0];
            c_in       = c_ff + COUNT_W'(1);
            crin_in    = crin_ff + rin_w;
            state_in   = S_CHECK;
         end
         S_FILL: begin
            // results past the last frame: the right neighbor clamps to it
            if (fill_go) begin
               hold_we = hold_room;
               c_in    = c_ff + COUNT_W'(1);
               crin_in = crin_ff + rin_w;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               if (slot_free) begin
                  e_in    = e_ff + COUNT_W'(1);
                  erin_in = erin_ff + rin_w;
                  nres_in = nres_ff + NRES_W'(1);
               end
            end else begin
               prev_in = mono_ff;
               if (end_ff) begin
                  k_in     = '0;
                  c_in     = '0;
                  e_in     = '0;
                  crin_in  = '0;
                  erin_in  = '0;
                  krout_in = '0;
               end else begin
                  k_in     = k_ff + FRAMES_W'(1);
                  krout_in = krout_n;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_rate_ff   <= RATE_RESET;
         out_rate_ff  <= RATE_RESET;
         chan_ff      <= CHAN_RESET;
         rin_ff       <= RATE_RESET;
         rout_ff      <= RATE_RESET;
         prev_ff      <= '0;
         end_ff       <= 1'b0;
         k_ff         <= '0;
         c_ff         <= '0;
         e_ff         <= '0;
         crin_ff      <= '0;
         erin_ff      <= '0;
         krout_ff     <= '0;
         step_ff      <= '0;
         nres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         chan_ff      <= chan_in;
         rin_ff       <= rin_in;
         rout_ff      <= rout_in;
         prev_ff      <= prev_in;
         end_ff       <= end_in;
         k_ff         <= k_in;
         c_ff         <= c_in;
         e_ff         <= e_in;
         crin_ff      <= crin_in;
         erin_ff      <= erin_in;
         krout_ff     <= krout_in;
         step_ff      <= step_in;
         nres_ff      <= nres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mono_ff     <= mono_in;
      diff_ff     <= diff_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      rsp_last_ff <= rsp_last_in;
   end

   // pending results, written at c and read at e
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_ff[c_ff[HOLD_AW-1:0]] <= hold_wdata;
      end
      if (rsp_load) begin
         rsp_data_ff <= hold_ff[e_ff[HOLD_AW-1:0]];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SDLR_CHECK(a_hold_room, state_ff == S_IDLE, COUNT_W'(c_ff - e_ff) < COUNT_W'(HOLD_SLOTS), "pending results exceed hold slots")
   `SDLR_CHECK(a_block_start_clear, (state_ff == S_IDLE) && (k_ff == '0), (c_ff == '0) && (e_ff == '0) && (krout_ff == '0) && (crin_ff == '0), "block counters not cleared at block start")
   `SDLR_CHECK(a_div_rem, state_ff == S_DIV, rem_ff < rout_ff, "division remainder out of range")
   `SDLR_CHECK_NEXT(a_block_close, (state_ff == S_EMIT) && !emit_ok && end_ff, (state_ff == S_IDLE) && (k_ff == '0), "block end did not close the block")

endmodule

`default_nettype wire
